// ===== src/packed_archive_entry_decoder_defines.svh =====
// assertion macros for the packed archive entry decoder
`ifndef PACKED_ARCHIVE_ENTRY_DECODER_DEFINES_SVH
`define PACKED_ARCHIVE_ENTRY_DECODER_DEFINES_SVH

// check that holds on the same clock edge as its trigger
`define PAK_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pak check failed");

// check that holds on the clock edge after its trigger
`define PAK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pak check failed");

`endif

// ===== src/pak_pkg.sv =====
// types, constants and header field helpers for the archive entry decoder
`timescale 1ns / 1ps

package pak_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_RELATIVE  = 2'd0;
    localparam logic [1:0] CFG_HDR_BYTES = 2'd1;
    localparam logic [1:0] CFG_REC_BYTES = 2'd2;

    // configuration reset values
    localparam logic       CFG_RELATIVE_RST  = 1'b1;
    localparam logic [7:0] CFG_HDR_BYTES_RST = 8'd53;
    localparam logic [7:0] CFG_REC_BYTES_RST = 8'd16;

    // result kinds
    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_BLOCK = 1'b1;

    // block size code that announces an explicit size word
    localparam logic [5:0] SIZE_CODE_EXPLICIT = 6'h3f;

    // serialized size width: 255 + 255 * 65535 + 4 fits
    localparam int SER_W = 24;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [31:0] data_word;
        logic        entry_start;
    } t_word_in;

    typedef struct packed {
        logic        record_kind;
        logic [63:0] entry_offset;
        logic [63:0] stored_size;
        logic [63:0] plain_size;
        logic [5:0]  method_index;
        logic        is_encrypted;
        logic [63:0] chunk_size;
        logic [15:0] chunk_count;
        logic [63:0] chunk_start;
        logic [63:0] chunk_end;
        logic        last;
    } t_result;

    typedef struct packed {
        logic       relative_chunk_offsets;
        logic [7:0] entry_header_bytes;
        logic [7:0] block_record_bytes;
    } t_cfg;

    // decoded event handed from the field decoder to the result builder
    typedef struct packed {
        logic             kind;
        logic             last;
        logic [63:0]      offset;
        logic [63:0]      plain;
        logic [63:0]      stored;
        logic [31:0]      header;
        logic [31:0]      expl_size;
        logic [SER_W-1:0] ser_size;
        logic [31:0]      word;
    } t_event;

    // entry fields repeated in every result of an entry
    typedef struct packed {
        logic [63:0] offset;
        logic [63:0] stored;
        logic [63:0] plain;
        logic [5:0]  method;
        logic        enc;
        logic [63:0] chunk_size;
        logic [15:0] count;
    } t_entry;

    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  room2;
    } t_fifo_stat;

    function automatic logic [5:0] hdr_code(input logic [31:0] h);
        return h[5:0];
    endfunction

    function automatic logic [15:0] hdr_count(input logic [31:0] h);
        return h[21:6];
    endfunction

    function automatic logic hdr_enc(input logic [31:0] h);
        return h[22];
    endfunction

    function automatic logic [5:0] hdr_method(input logic [31:0] h);
        return h[28:23];
    endfunction

    function automatic logic hdr_stored_narrow(input logic [31:0] h);
        return h[29];
    endfunction

    function automatic logic hdr_plain_narrow(input logic [31:0] h);
        return h[30];
    endfunction

    function automatic logic hdr_offset_narrow(input logic [31:0] h);
        return h[31];
    endfunction

endpackage

// ===== src/pak_chan_if.sv =====
// valid/ready channel carrying one payload word
`timescale 1ns / 1ps

interface pak_chan_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/pak_field_fsm.sv =====
// field decoder: walks the entry record word by word and raises events
`timescale 1ns / 1ps

module pak_field_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pak_pkg::t_word_in i_in_word,
    output logic             o_in_ready,
    input  logic             i_ev_take,
    input  pak_pkg::t_cfg    i_cfg,
    output logic             o_ev_valid,
    output pak_pkg::t_event  o_event
);
    import pak_pkg::*;

    localparam logic [3:0] PH_HEADER    = 4'd0;
    localparam logic [3:0] PH_CHUNKSZ   = 4'd1;
    localparam logic [3:0] PH_OFF_LO    = 4'd2;
    localparam logic [3:0] PH_OFF_HI    = 4'd3;
    localparam logic [3:0] PH_PLAIN_LO  = 4'd4;
    localparam logic [3:0] PH_PLAIN_HI  = 4'd5;
    localparam logic [3:0] PH_STORED_LO = 4'd6;
    localparam logic [3:0] PH_STORED_HI = 4'd7;
    localparam logic [3:0] PH_BLOCKS    = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [31:0] r_header, n_header;
    logic [31:0] r_low, n_low;
    logic [63:0] r_offset, n_offset;
    logic [63:0] r_plain, n_plain;
    logic [63:0] r_stored, n_stored;
    logic [31:0] r_expl, n_expl;
    logic [15:0] r_chunks_left, n_chunks_left;
    logic        r_ev_valid, n_ev_valid;
    t_event      r_event, n_event;

    logic        accept;
    logic [3:0]  cur_phase;
    logic [31:0] w;
    logic        plain_done;
    logic        finish;
    logic        blk;
    logic        blk_last;
    logic [15:0] count;

    assign o_in_ready = !r_ev_valid || i_ev_take;
    assign accept     = i_in_valid && o_in_ready;
    assign w          = i_in_word.data_word;
    assign count      = hdr_count(r_header);
    assign o_ev_valid = r_ev_valid;
    assign o_event    = r_event;

    // entry start or a stray code restarts at the header
    assign cur_phase = (i_in_word.entry_start || r_phase > PH_BLOCKS) ? PH_HEADER : r_phase;

    // phase walk and field capture
    always_comb begin
        n_phase       = r_phase;
        n_header      = r_header;
        n_low         = r_low;
        n_offset      = r_offset;
        n_plain       = r_plain;
        n_stored      = r_stored;
        n_expl        = r_expl;
        n_chunks_left = r_chunks_left;
        plain_done    = 1'b0;
        finish        = 1'b0;
        blk           = 1'b0;
        blk_last      = 1'b0;
        if (accept) begin
            unique case (cur_phase)
                PH_HEADER: begin
                    n_header      = w;
                    n_expl        = '0;
                    n_offset      = '0;
                    n_plain       = '0;
                    n_stored      = '0;
                    n_chunks_left = '0;
                    n_phase = (hdr_code(w) == SIZE_CODE_EXPLICIT) ? PH_CHUNKSZ : PH_OFF_LO;
                end
                PH_CHUNKSZ: begin
                    n_expl  = w;
                    n_phase = PH_OFF_LO;
                end
                PH_OFF_LO: begin
                    if (hdr_offset_narrow(r_header)) begin
                        n_offset = {32'd0, w};
                        n_phase  = PH_PLAIN_LO;
                    end else begin
                        n_low   = w;
                        n_phase = PH_OFF_HI;
                    end
                end
                PH_OFF_HI: begin
                    n_offset = {w, r_low};
                    n_phase  = PH_PLAIN_LO;
                end
                PH_PLAIN_LO: begin
                    if (hdr_plain_narrow(r_header)) begin
                        n_plain    = {32'd0, w};
                        plain_done = 1'b1;
                    end else begin
                        n_low   = w;
                        n_phase = PH_PLAIN_HI;
                    end
                end
                PH_PLAIN_HI: begin
                    n_plain    = {w, r_low};
                    plain_done = 1'b1;
                end
                PH_STORED_LO: begin
                    if (hdr_stored_narrow(r_header)) begin
                        n_stored = {32'd0, w};
                        finish   = 1'b1;
                    end else begin
                        n_low   = w;
                        n_phase = PH_STORED_HI;
                    end
                end
                PH_STORED_HI: begin
                    n_stored = {w, r_low};
                    finish   = 1'b1;
                end
                default: begin
                    blk           = 1'b1;
                    n_chunks_left = r_chunks_left - 16'd1;
                    blk_last      = (n_chunks_left == 16'd0);
                    if (blk_last) begin
                        n_phase = PH_HEADER;
                    end
                end
            endcase

            // uncompressed entries carry no stored size
            if (plain_done) begin
                if (hdr_method(r_header) != 6'd0) begin
                    n_phase = PH_STORED_LO;
                end else begin
                    n_stored = n_plain;
                    finish   = 1'b1;
                end
            end

            // entry complete: block words follow unless the table is implicit
            if (finish) begin
                if (count == 16'd0 || (count == 16'd1 && !hdr_enc(r_header))) begin
                    n_phase = PH_HEADER;
                end else begin
                    n_chunks_left = count;
                    n_phase       = PH_BLOCKS;
                end
            end
        end
    end

    // event payload, with the serialized header size
    always_comb begin
        n_event.kind      = blk ? KIND_BLOCK : KIND_ENTRY;
        n_event.last      = blk_last;
        n_event.offset    = n_offset;
        n_event.plain     = n_plain;
        n_event.stored    = n_stored;
        n_event.header    = r_header;
        n_event.expl_size = r_expl;
        n_event.word      = w;
        n_event.ser_size  = SER_W'(i_cfg.entry_header_bytes);
        if (hdr_method(r_header) != 6'd0) begin
            n_event.ser_size = n_event.ser_size
                + SER_W'(i_cfg.block_record_bytes) * SER_W'(count) + SER_W'(4);
        end
        if (accept && (finish || blk)) begin
            n_ev_valid = 1'b1;
        end else if (i_ev_take) begin
            n_ev_valid = 1'b0;
        end else begin
            n_ev_valid = r_ev_valid;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_chunks_left <= '0;
            r_ev_valid    <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_chunks_left <= n_chunks_left;
            r_ev_valid    <= n_ev_valid;
        end
    end

    // field and event payload registers
    always_ff @(posedge i_clk) begin
        r_header <= n_header;
        r_low    <= n_low;
        r_offset <= n_offset;
        r_plain  <= n_plain;
        r_stored <= n_stored;
        r_expl   <= n_expl;
        if (accept && (finish || blk)) begin
            r_event <= n_event;
        end
    end

endmodule

// ===== src/pak_result_emit.sv =====
// result builder: block addressing and result words for each event
`timescale 1ns / 1ps

module pak_result_emit (
    input  logic            i_clk,
    input  logic            i_ev_valid,
    input  pak_pkg::t_event i_event,
    input  pak_pkg::t_cfg   i_cfg,
    input  logic            i_room2,
    output logic            o_ev_take,
    output pak_pkg::t_push  o_push
);
    import pak_pkg::*;

    logic [63:0] r_ncs;
    t_entry      r_ent;

    t_entry      new_ent;
    logic [15:0] count;
    logic [63:0] base;
    logic [63:0] ent_ncs;
    logic [63:0] ent_end;
    logic [32:0] step_round;
    logic [63:0] blk_step;
    logic [63:0] blk_end;
    logic        is_entry;
    logic        implicit_blk;

    function automatic t_result mk_result(input t_entry e, input logic kind,
                                          input logic [63:0] cs, input logic [63:0] ce,
                                          input logic last);
        t_result r;
        r.record_kind  = kind;
        r.entry_offset = e.offset;
        r.stored_size  = e.stored;
        r.plain_size   = e.plain;
        r.method_index = e.method;
        r.is_encrypted = e.enc;
        r.chunk_size   = e.chunk_size;
        r.chunk_count  = e.count;
        r.chunk_start  = cs;
        r.chunk_end    = ce;
        r.last         = last;
        return r;
    endfunction

    assign o_ev_take = i_ev_valid && i_room2;
    assign is_entry  = (i_event.kind == KIND_ENTRY);
    assign count     = hdr_count(i_event.header);

    // entry fields and chunk size
    always_comb begin
        new_ent.offset = i_event.offset;
        new_ent.stored = i_event.stored;
        new_ent.plain  = i_event.plain;
        new_ent.method = hdr_method(i_event.header);
        new_ent.enc    = hdr_enc(i_event.header);
        new_ent.count  = count;
        if (count == 16'd0) begin
            new_ent.chunk_size = '0;
        end else if (count == 16'd1) begin
            new_ent.chunk_size = i_event.plain;
        end else if (hdr_code(i_event.header) == SIZE_CODE_EXPLICIT) begin
            new_ent.chunk_size = {32'd0, i_event.expl_size};
        end else begin
            new_ent.chunk_size = {47'd0, hdr_code(i_event.header), 11'd0};
        end
    end

    // first block start, and end of an implicit single block
    assign base         = i_cfg.relative_chunk_offsets ? 64'd0 : i_event.offset;
    assign ent_ncs      = base + 64'(i_event.ser_size);
    assign ent_end      = base + 64'(i_event.ser_size) + i_event.stored;
    assign implicit_blk = (count == 16'd1) && !hdr_enc(i_event.header);

    // block step, rounded up to a multiple of 16 bytes when encrypted
    assign step_round = {1'b0, i_event.word} + 33'd15;
    assign blk_step   = r_ent.enc ? {31'd0, step_round[32:4], 4'd0} : {32'd0, i_event.word};
    assign blk_end    = r_ncs + {32'd0, i_event.word};

    // result words
    always_comb begin
        o_push.push0 = o_ev_take;
        o_push.push1 = o_ev_take && is_entry && implicit_blk;
        if (is_entry) begin
            o_push.res0 = mk_result(new_ent, KIND_ENTRY, 64'd0, 64'd0, count == 16'd0);
        end else begin
            o_push.res0 = mk_result(r_ent, KIND_BLOCK, r_ncs, blk_end, i_event.last);
        end
        o_push.res1 = mk_result(new_ent, KIND_BLOCK, ent_ncs, ent_end, 1'b1);
    end

    // running block start and entry snapshot
    always_ff @(posedge i_clk) begin
        if (o_ev_take) begin
            if (is_entry) begin
                r_ent <= new_ent;
                r_ncs <= ent_ncs;
            end else begin
                r_ncs <= r_ncs + blk_step;
            end
        end
    end

endmodule

// ===== src/pak_result_fifo.sv =====
// result queue: takes one or two words a cycle, gives one while the reader is ready
`timescale 1ns / 1ps

module pak_result_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pak_pkg::t_push      i_push,
    output logic                o_valid,
    output pak_pkg::t_result    o_data,
    input  logic                i_ready,
    output pak_pkg::t_fifo_stat o_stat
);
    import pak_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  pop;
    logic [FIFO_PTR_W-1:0] wr_ptr_1;

    assign o_valid      = (r_count != '0);
    assign o_data       = r_mem[r_rd_ptr];
    assign pop          = o_valid && i_ready;
    assign wr_ptr_1     = FIFO_PTR_W'(r_wr_ptr + 1'b1);
    assign o_stat.count = r_count;
    assign o_stat.room2 = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    // pointer and fill level update
    always_comb begin
        n_wr_ptr = FIFO_PTR_W'(r_wr_ptr + FIFO_PTR_W'(i_push.push0) + FIFO_PTR_W'(i_push.push1));
        n_rd_ptr = FIFO_PTR_W'(r_rd_ptr + FIFO_PTR_W'(pop));
        n_count  = FIFO_CNT_W'(r_count + FIFO_CNT_W'(i_push.push0)
                   + FIFO_CNT_W'(i_push.push1) - FIFO_CNT_W'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, second word lands behind the first
    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[wr_ptr_1] <= i_push.res1;
        end
    end

endmodule

// ===== src/packed_archive_entry_decoder.sv =====
// top level of the packed archive entry decoder
`timescale 1ns / 1ps
`include "packed_archive_entry_decoder_defines.svh"

// Takes one 32-bit word of an entry record per cycle while input is not held off,
// and gives one result word per cycle while the receiver is ready. The word that
// completes an entry's fields yields the entry result, and for a single
// unencrypted block also that block's result, so such a word puts two results
// into the queue in one cycle; every block size word yields one. A result passes
// through the event register after the field decoder, then the four-deep result
// queue. Input is held off only while the queue has less than two free places.
module packed_archive_entry_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pak_chan_if.sink      i_word,
    pak_chan_if.source    o_result,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data
);
    import pak_pkg::*;

    t_cfg       r_cfg;
    logic       ev_valid;
    t_event     ev;
    logic       ev_take;
    t_push      push;
    t_fifo_stat fifo_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.relative_chunk_offsets <= CFG_RELATIVE_RST;
            r_cfg.entry_header_bytes     <= CFG_HDR_BYTES_RST;
            r_cfg.block_record_bytes     <= CFG_REC_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RELATIVE:  r_cfg.relative_chunk_offsets <= i_cfg_data[0];
                CFG_HDR_BYTES: r_cfg.entry_header_bytes     <= i_cfg_data;
                CFG_REC_BYTES: r_cfg.block_record_bytes     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // field decoder
    pak_field_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_word.valid),
        .i_in_word  (i_word.payload),
        .o_in_ready (i_word.ready),
        .i_ev_take  (ev_take),
        .i_cfg      (r_cfg),
        .o_ev_valid (ev_valid),
        .o_event    (ev)
    );

    // result builder
    pak_result_emit u_emit (
        .i_clk      (i_clk),
        .i_ev_valid (ev_valid),
        .i_event    (ev),
        .i_cfg      (r_cfg),
        .i_room2    (fifo_stat.room2),
        .o_ev_take  (ev_take),
        .o_push     (push)
    );

    // result queue
    pak_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_valid (o_result.valid),
        .o_data  (o_result.payload),
        .i_ready (o_result.ready),
        .o_stat  (fifo_stat)
    );

    // a stalled event stays put until the builder takes it
    `PAK_ASSERT_NEXT(a_ev_hold, i_clk, i_rst_n, ev_valid && !ev_take, ev_valid && $stable(ev))
    // a taken block event always leaves a word in the queue
    `PAK_ASSERT_NEXT(a_blk_queued, i_clk, i_rst_n, ev_take && ev.kind == KIND_BLOCK, fifo_stat.count != '0)
    // the queue never overfills
    `PAK_ASSERT_SAME(a_fifo_bound, i_clk, i_rst_n, 1'b1, fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH))

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the packed archive entry decoder: directed and random records
`timescale 1ns / 1ps

module testbench;
    import pak_pkg::*;

    // decode position within one entry record
    typedef enum logic [3:0] {
        REC_HEADER,
        REC_CHUNK_SIZE,
        REC_OFFSET_LO,
        REC_OFFSET_HI,
        REC_PLAIN_LO,
        REC_PLAIN_HI,
        REC_STORED_LO,
        REC_STORED_HI,
        REC_BLOCKS
    } rec_phase_e;

    // predicts entry and block results and checks them in order
    class entry_result_board;
        logic       rel_offsets;
        logic [7:0] hdr_bytes;
        logic [7:0] rec_bytes;

        rec_phase_e  phase;
        logic [31:0] header;
        logic [31:0] low_half;
        logic [31:0] expl_size;
        logic [63:0] offset;
        logic [63:0] plain;
        logic [63:0] stored;
        logic [63:0] next_start;
        logic [15:0] chunks_left;

        t_result awaited[$];
        int      errors;
        int      words_seen;
        int      entry_results;
        int      block_results;

        function new();
            rel_offsets   = CFG_RELATIVE_RST;
            hdr_bytes     = CFG_HDR_BYTES_RST;
            rec_bytes     = CFG_REC_BYTES_RST;
            phase         = REC_HEADER;
            header        = '0;
            low_half      = '0;
            expl_size     = '0;
            offset        = '0;
            plain         = '0;
            stored        = '0;
            next_start    = '0;
            chunks_left   = '0;
            errors        = 0;
            words_seen    = 0;
            entry_results = 0;
            block_results = 0;
        endfunction

        function void write_reg(input logic [1:0] index, input logic [7:0] value);
            case (index)
                CFG_RELATIVE:  rel_offsets = value[0];
                CFG_HDR_BYTES: hdr_bytes = value;
                CFG_REC_BYTES: rec_bytes = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // append one predicted result word
        function void expect_result(input t_result r);
            awaited.insert(awaited.size(), r);
        endfunction

        // block size as reported in every result of the entry
        function logic [63:0] chunk_size_for();
            if (header[21:6] == 16'd0) return 64'd0;
            if (header[21:6] == 16'd1) return plain;
            if (header[5:0] == SIZE_CODE_EXPLICIT) return {32'd0, expl_size};
            return {47'd0, header[5:0], 11'd0};
        endfunction

        function t_result make_result(input logic kind, input logic [63:0] start,
                                      input logic [63:0] stop, input logic is_last);
            t_result r;
            r.record_kind  = kind;
            r.entry_offset = offset;
            r.stored_size  = stored;
            r.plain_size   = plain;
            r.method_index = header[28:23];
            r.is_encrypted = header[22];
            r.chunk_size   = chunk_size_for();
            r.chunk_count  = header[21:6];
            r.chunk_start  = start;
            r.chunk_end    = stop;
            r.last         = is_last;
            return r;
        endfunction

        // all entry fields known: entry result, maybe the implicit block
        function void close_entry();
            logic [63:0] ser;
            logic [63:0] base;
            logic [15:0] n;
            n   = header[21:6];
            ser = {56'd0, hdr_bytes};
            if (header[28:23] != 6'd0) ser = ser + {56'd0, rec_bytes} * {48'd0, n} + 64'd4;
            base       = rel_offsets ? 64'd0 : offset;
            next_start = base + ser;
            phase      = REC_HEADER;
            if (n == 16'd0) begin
                expect_result(make_result(KIND_ENTRY, 64'd0, 64'd0, 1'b1));
            end else if (n == 16'd1 && !header[22]) begin
                expect_result(make_result(KIND_ENTRY, 64'd0, 64'd0, 1'b0));
                expect_result(make_result(KIND_BLOCK, next_start, next_start + stored, 1'b1));
            end else begin
                expect_result(make_result(KIND_ENTRY, 64'd0, 64'd0, 1'b0));
                chunks_left = n;
                phase       = REC_BLOCKS;
            end
        endfunction

        function void plain_done();
            if (header[28:23] != 6'd0) begin
                phase = REC_STORED_LO;
            end else begin
                stored = plain;
                close_entry();
            end
        endfunction

        function void take_word(input t_word_in wi);
            logic [31:0] w;
            logic [63:0] start;
            logic [63:0] step;
            w = wi.data_word;
            words_seen++;
            if (wi.entry_start) phase = REC_HEADER;
            case (phase)
                REC_HEADER: begin
                    header      = w;
                    expl_size   = '0;
                    offset      = '0;
                    plain       = '0;
                    stored      = '0;
                    chunks_left = '0;
                    phase = (w[5:0] == SIZE_CODE_EXPLICIT) ? REC_CHUNK_SIZE : REC_OFFSET_LO;
                end
                REC_CHUNK_SIZE: begin
                    expl_size = w;
                    phase     = REC_OFFSET_LO;
                end
                REC_OFFSET_LO: begin
                    if (header[31]) begin
                        offset = {32'd0, w};
                        phase  = REC_PLAIN_LO;
                    end else begin
                        low_half = w;
                        phase    = REC_OFFSET_HI;
                    end
                end
                REC_OFFSET_HI: begin
                    offset = {w, low_half};
                    phase  = REC_PLAIN_LO;
                end
                REC_PLAIN_LO: begin
                    if (header[30]) begin
                        plain = {32'd0, w};
                        plain_done();
                    end else begin
                        low_half = w;
                        phase    = REC_PLAIN_HI;
                    end
                end
                REC_PLAIN_HI: begin
                    plain = {w, low_half};
                    plain_done();
                end
                REC_STORED_LO: begin
                    if (header[29]) begin
                        stored = {32'd0, w};
                        close_entry();
                    end else begin
                        low_half = w;
                        phase    = REC_STORED_HI;
                    end
                end
                REC_STORED_HI: begin
                    stored = {w, low_half};
                    close_entry();
                end
                default: begin
                    // block length word; encrypted blocks advance by a 16-byte multiple
                    start = next_start;
                    step  = {32'd0, w};
                    if (header[22]) step = (step + 64'd15) & ~64'd15;
                    next_start  = start + step;
                    chunks_left = chunks_left - 16'd1;
                    expect_result(make_result(KIND_BLOCK, start, start + {32'd0, w},
                                              chunks_left == 16'd0));
                    if (chunks_left == 16'd0) phase = REC_HEADER;
                end
            endcase
        endfunction

        function void check_field(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void match_result(input t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, kind %0d start %h end %h", $time,
                         got.record_kind, got.chunk_start, got.chunk_end);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (want.record_kind == KIND_ENTRY) entry_results++;
            else block_results++;
            check_field("record_kind", 64'(want.record_kind), 64'(got.record_kind));
            check_field("entry_offset", want.entry_offset, got.entry_offset);
            check_field("stored_size", want.stored_size, got.stored_size);
            check_field("plain_size", want.plain_size, got.plain_size);
            check_field("method_index", 64'(want.method_index), 64'(got.method_index));
            check_field("is_encrypted", 64'(want.is_encrypted), 64'(got.is_encrypted));
            check_field("chunk_size", want.chunk_size, got.chunk_size);
            check_field("chunk_count", 64'(want.chunk_count), 64'(got.chunk_count));
            check_field("chunk_start", want.chunk_start, got.chunk_start);
            check_field("chunk_end", want.chunk_end, got.chunk_end);
            check_field("last", 64'(want.last), 64'(got.last));
        endfunction

        function void drop_missing();
            $display("%0t: %0d expected results never arrived", $time, awaited.size());
            errors += awaited.size();
            awaited.delete();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    pak_chan_if #(.T_PAYLOAD(t_word_in)) word_if ();
    pak_chan_if #(.T_PAYLOAD(t_result))  result_if ();

    packed_archive_entry_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (word_if),
        .o_result    (result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    entry_result_board board;
    t_word_in          word_q[$];
    logic [31:0]       block_lens[$];
    bit                idle_free = 1'b0;
    bit                stall_free = 1'b0;
    int                settings_used = 1;

    // clock
    always #5 i_clk = ~i_clk;

    // result sink with random back-pressure
    always @(negedge i_clk) begin
        if (stall_free) result_if.ready <= 1'b1;
        else result_if.ready <= ($urandom_range(0, 99) >= 32);
    end

    // watch both channels at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) board.match_result(result_if.payload);
            if (word_if.valid && word_if.ready) board.take_word(word_if.payload);
        end
    end

    function automatic logic [31:0] make_header(input logic off_narrow, input logic plain_narrow,
                                                input logic stored_narrow, input logic [5:0] meth,
                                                input logic enc, input logic [15:0] n,
                                                input logic [5:0] code);
        return {off_narrow, plain_narrow, stored_narrow, meth, enc, n, code};
    endfunction

    function automatic logic [31:0] rand_header(input bit short_only);
        logic [5:0]  code;
        logic [15:0] n;
        logic [5:0]  meth;
        int          r;
        code = 6'($urandom_range(0, 63));
        r    = $urandom_range(0, 99);
        if (r < 20) code = SIZE_CODE_EXPLICIT;
        else if (r < 25) code = 6'd0;
        r = $urandom_range(0, 99);
        if (short_only) n = 16'($urandom_range(0, 4));
        else if (r < 20) n = 16'd0;
        else if (r < 45) n = 16'd1;
        else if (r < 85) n = 16'($urandom_range(2, 4));
        else if (r < 95) n = 16'($urandom_range(5, 12));
        else n = 16'($urandom_range(13, 65535));
        meth = ($urandom_range(0, 99) < 30) ? 6'd0 : 6'($urandom_range(1, 63));
        return make_header(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), meth, 1'($urandom_range(0, 1)), n, code);
    endfunction

    // length words that follow the entry fields
    function automatic int blocks_needed(input logic [31:0] h);
        if (h[21:6] == 16'd0 || (h[21:6] == 16'd1 && !h[22])) return 0;
        return int'(h[21:6]);
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 64'd0;
            1:       return '1;
            2:       return {32'd0, $urandom};
            3:       return {$urandom, $urandom};
            default: return 64'($urandom_range(0, 100000));
        endcase
    endfunction

    function automatic logic [31:0] pick_len();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(0, 64);
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    // append one word to the send queue
    function automatic void queue_word(input t_word_in wi);
        word_q.insert(word_q.size(), wi);
    endfunction

    // append one block length for the next record
    function automatic void queue_len(input logic [31:0] len);
        block_lens.insert(block_lens.size(), len);
    endfunction

    // queue the words of one record; block lengths come from block_lens
    function automatic void add_record(input logic [31:0] h, input logic s,
                                       input logic [31:0] expl, input logic [63:0] off,
                                       input logic [63:0] plain, input logic [63:0] stored);
        queue_word(t_word_in'({h, s}));
        if (h[5:0] == SIZE_CODE_EXPLICIT) queue_word(t_word_in'({expl, 1'b0}));
        queue_word(t_word_in'({off[31:0], 1'b0}));
        if (!h[31]) queue_word(t_word_in'({off[63:32], 1'b0}));
        queue_word(t_word_in'({plain[31:0], 1'b0}));
        if (!h[30]) queue_word(t_word_in'({plain[63:32], 1'b0}));
        if (h[28:23] != 6'd0) begin
            queue_word(t_word_in'({stored[31:0], 1'b0}));
            if (!h[29]) queue_word(t_word_in'({stored[63:32], 1'b0}));
        end
        foreach (block_lens[i]) queue_word(t_word_in'({block_lens[i], 1'b0}));
        block_lens.delete();
    endfunction

    // random record, sometimes cut short; returns 1 when left incomplete
    function automatic bit random_record(input logic s);
        logic [31:0] h;
        int          nblk;
        int          rec_first;
        bit          broken;
        h      = rand_header(1'b0);
        nblk   = blocks_needed(h);
        broken = 1'b0;
        if (nblk > 12) begin
            nblk   = $urandom_range(0, 8);
            broken = 1'b1;
        end
        repeat (nblk) queue_len(pick_len());
        rec_first = word_q.size();
        add_record(h, s, $urandom, pick_value(), pick_value(), pick_value());
        if (!broken && $urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, word_q.size() - rec_first - 1))
                word_q.delete(word_q.size() - 1);
            broken = 1'b1;
        end
        return broken;
    endfunction

    task automatic push_word(input t_word_in wi);
        while (!idle_free && $urandom_range(0, 99) < 32) begin
            word_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        word_if.valid   <= 1'b1;
        word_if.payload <= wi;
        @(posedge i_clk);
        while (!word_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_queued();
        while (word_q.size() != 0) push_word(word_q.pop_front());
    endtask

    // hold the sender until every expected result is in or the wait times out, then idle
    task automatic settle();
        int waited;
        waited = 0;
        word_if.valid <= 1'b0;
        while (board.pending() != 0 && waited < 4000) begin
            @(negedge i_clk);
            waited++;
        end
        if (board.pending() != 0) board.drop_missing();
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic rel, input logic [7:0] hb, input logic [7:0] rb);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_RELATIVE;
        i_cfg_data  <= {7'd0, rel};
        board.write_reg(CFG_RELATIVE, {7'd0, rel});
        @(negedge i_clk);
        i_cfg_index <= CFG_HDR_BYTES;
        i_cfg_data  <= hb;
        board.write_reg(CFG_HDR_BYTES, hb);
        @(negedge i_clk);
        i_cfg_index <= CFG_REC_BYTES;
        i_cfg_data  <= rb;
        board.write_reg(CFG_REC_BYTES, rb);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_directed();
        // no blocks, uncompressed, all narrow, entry start while idle
        add_record(make_header(1'b1, 1'b1, 1'b1, 6'd0, 1'b0, 16'd0, 6'd0), 1'b1,
                   32'd0, 64'hFFFF_FFFF, 64'd0, 64'd0);
        // single implicit block, all wide at the extremes, explicit size word
        add_record(make_header(1'b0, 1'b0, 1'b0, 6'h3f, 1'b0, 16'd1, SIZE_CODE_EXPLICIT), 1'b0,
                   32'hFFFF_FFFF, '1, 64'h8000_0000_0000_0001, '1);
        // encrypted single block reads a length word
        block_lens = {32'hFFFF_FFFF};
        add_record(make_header(1'b1, 1'b1, 1'b1, 6'd1, 1'b1, 16'd1, 6'd62), 1'b0,
                   32'd0, 64'h1234_5678, 64'h9ABC_DEF0, 64'd7);
        // full block count, encrypted alignment, dropped after three blocks
        block_lens = {32'h11, 32'h0, 32'hFFFF_FFFF};
        add_record(make_header(1'b0, 1'b1, 1'b0, 6'd0, 1'b1, 16'hFFFF, SIZE_CODE_EXPLICIT),
                   1'b0, 32'd0, 64'hFEDC_BA98_7654_3210, 64'h55, 64'd0);
        // entry start in the middle of the block list above
        block_lens = {32'd1, 32'd2};
        add_record(make_header(1'b1, 1'b1, 1'b1, 6'd5, 1'b0, 16'd2, 6'd0), 1'b1,
                   32'd0, 64'h100, 64'h2000, 64'h1800);
        send_queued();
        settle();
    endtask

    task automatic run_phase(input int n_words);
        int          sent;
        bit          need_start;
        logic [31:0] h;
        sent       = 0;
        need_start = 1'b1;
        while (sent < n_words) begin
            if ($urandom_range(0, 99) < 5) begin
                // loose words with no record structure
                repeat ($urandom_range(1, 3))
                    queue_word(t_word_in'({$urandom, 1'($urandom_range(0, 1))}));
                need_start = 1'b1;
            end else begin
                need_start = random_record(need_start || ($urandom_range(0, 1) == 1));
            end
            sent += word_q.size();
            send_queued();
            if ($urandom_range(0, 99) < 2) settle();
        end
        // close on a complete record so the decoder is back at a header
        h = rand_header(1'b1);
        repeat (blocks_needed(h)) queue_len(pick_len());
        add_record(h, 1'b1, $urandom, pick_value(), pick_value(), pick_value());
        send_queued();
        settle();
    endtask

    // run time limit
    initial begin
        #20_000_000;
        $display("packed_archive_entry_decoder regression: fail");
        $finish;
    end

    initial begin
        board           = new();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_RELATIVE;
        i_cfg_data      = 8'd0;
        word_if.valid   = 1'b0;
        word_if.payload = '0;
        result_if.ready = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_directed();

        for (int p = 0; p < 6; p++) begin
            // one phase runs with no idling on either side
            idle_free  = (p == 2);
            stall_free = (p == 2);
            case (p)
                1: apply_setting(1'b0, 8'd255, 8'd255);
                2: apply_setting(1'b1, 8'd0, 8'd0);
                3: apply_setting(1'b0, 8'd0, 8'd255);
                4: apply_setting(1'b1, 8'd255, 8'($urandom));
                5: apply_setting(1'b0, 8'($urandom), 8'($urandom));
                default: ;
            endcase
            run_phase(215);
        end

        $display("covered %0d words under %0d register settings", board.words_seen,
                 settings_used);
        $display("checked %0d entry results and %0d block results, %0d errors",
                 board.entry_results, board.block_results, board.errors);
        if (board.errors == 0) begin
            $display("packed_archive_entry_decoder regression: pass");
        end else begin
            $display("packed_archive_entry_decoder regression: fail");
        end
        $finish;
    end

endmodule

// ===== packed_archive_entry_decoder.f =====
+incdir+src
src/pak_pkg.sv
src/pak_chan_if.sv
src/pak_field_fsm.sv
src/pak_result_emit.sv
src/pak_result_fifo.sv
src/packed_archive_entry_decoder.sv
test/testbench.sv
